// File: rtl/core/great_circle_distance_unit_macros.svh
// Assertion shorthands for the distance unit.
`ifndef GREAT_CIRCLE_DISTANCE_UNIT_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_UNIT_MACROS_SVH

// Same-cycle implication.
`define GCD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GCD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/gcd_pkg.sv
package gcd_pkg;

    localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;
    localparam logic [63:0] UNITS_PER_PI = 64'd1800000000;
    // 2R = 12742017.6 m in Q32
    localparam logic [63:0] TWO_R_Q32    = (64'd12742017 << 32) + 64'd2576980378;
    localparam int          DIST_W       = 25;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Restoring long division, elaboration only.
    function automatic logic [127:0] udiv128(input logic [127:0] n, input logic [127:0] d);
        logic [127:0] q;
        logic [127:0] r;
        q = '0;
        r = '0;
        for (int j = 127; j >= 0; j--) begin
            r = {r[126:0], n[j]};
            if (r >= d) begin
                r = r - d;
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // Quotient rounded to nearest, ties up.
    function automatic logic [127:0] udiv_round(input logic [127:0] n, input logic [127:0] d);
        logic [127:0] q;
        logic [127:0] r;
        q = udiv128(n, d);
        r = n - q * d;
        if ((r << 1) >= d) begin
            q = q + 128'd1;
        end
        return q;
    endfunction

    function automatic logic [63:0] isqrt128(input logic [127:0] n, input int top);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = top; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ((128'(c) * 128'(c)) <= n) begin
                r = c;
            end
        end
        return r;
    endfunction

    // atan(2^-i) in Q(f); odd power series summed in Q62 first.
    function automatic logic [63:0] stage_angle(input int f, input int i);
        logic [63:0]  v;
        logic [127:0] t;
        int           e;
        v = '0;
        if (i == 0) begin
            v = PI_Q60;
        end else begin
            for (int k = 0; k < 32; k++) begin
                e = 62 - i * (2 * k + 1);
                if (e >= 0) begin
                    t = udiv128(128'd1 << e, 128'(2 * k + 1));
                    if (k[0]) begin
                        v = v - t[63:0];
                    end else begin
                        v = v + t[63:0];
                    end
                end
            end
        end
        return (v + (64'd1 << (61 - f))) >> (62 - f);
    endfunction

    // Start x of the rotation chain: round(2^f / G).
    function automatic logic [63:0] cordic_x0(input int f, input int n);
        logic [63:0]  p;
        logic [63:0]  g;
        logic [127:0] q;
        p = 64'd1 << 62;
        for (int i = 0; i < n; i++) begin
            if (2 * i < 64) begin
                p = p + (p >> (2 * i));
            end
        end
        g = isqrt128({2'b00, p, 62'd0}, 62);
        q = udiv_round(128'd1 << (f + 62), 128'(g));
        return q[63:0];
    endfunction

    // pi / 1.8e9 in Q92
    function automatic logic [63:0] unit_rad_fix();
        logic [127:0] q;
        q = udiv_round({32'd0, PI_Q60, 32'd0}, 128'(UNITS_PER_PI));
        return q[63:0];
    endfunction

    function automatic logic [63:0] pi_q_fix(input int f);
        return (PI_Q60 + (64'd1 << (59 - f))) >> (60 - f);
    endfunction

endpackage

// File: rtl/core/gcd_mulrnd.sv
// Signed multiply, round to nearest (ties away from zero), shift right SH.
// Two stages: split partial products, then sum/round/sign.
module gcd_mulrnd #(
    parameter int AWD = 32,
    parameter int BWD = 32,
    parameter int SH  = 16,
    parameter int OW  = 32
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [AWD-1:0] a,
    input  logic signed [BWD-1:0] b,
    output logic signed [OW-1:0]  p
);

    localparam int BLW = BWD / 2;
    localparam int BHW = BWD - BLW;
    localparam int SW  = AWD + BWD + OW + 1;

    logic [AWD-1:0]     ma;
    logic [BWD-1:0]     mb;
    logic               neg;
    logic [AWD+BLW-1:0] plo_reg;
    logic [AWD+BHW-1:0] phi_reg;
    logic               neg_reg;
    logic [SW-1:0]      sum;
    logic [OW-1:0]      q;
    logic signed [OW-1:0] p_reg, p_next;

    assign ma  = a[AWD-1] ? (~$unsigned(a) + {{(AWD-1){1'b0}}, 1'b1}) : $unsigned(a);
    assign mb  = b[BWD-1] ? (~$unsigned(b) + {{(BWD-1){1'b0}}, 1'b1}) : $unsigned(b);
    assign neg = a[AWD-1] ^ b[BWD-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            plo_reg <= ma * mb[BLW-1:0];
            phi_reg <= ma * mb[BWD-1:BLW];
            neg_reg <= neg;
        end
    end

    always_comb begin
        sum    = SW'(plo_reg) + (SW'(phi_reg) << BLW) + (SW'(1) << (SH - 1));
        q      = sum[SH +: OW];
        p_next = neg_reg ? $signed(-q) : $signed(q);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// File: rtl/core/gcd_sincos.sv
// Sine/cosine: range reduction (2 stages), N rotation stages, sign fix-up.
module gcd_sincos
    import gcd_pkg::*;
#(
    parameter int F  = 30,
    parameter int N  = 32,
    parameter int AW = 35
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [AW-1:0] a,
    output logic signed [AW-1:0] sn,
    output logic signed [AW-1:0] cs
);

    localparam logic signed [AW-1:0] PI_Q   = AW'(pi_q_fix(F));
    localparam logic signed [AW-1:0] TWO_PI = PI_Q + PI_Q;
    localparam logic signed [AW-1:0] HALF   = PI_Q >>> 1;
    localparam logic signed [AW-1:0] X0     = AW'(cordic_x0(F, N));

    logic signed [AW-1:0] a1_reg, a1_next;
    logic signed [AW-1:0] z0_reg, z0_next;
    logic                 neg0_reg, neg0_next;
    logic signed [AW-1:0] x_reg [N];
    logic signed [AW-1:0] y_reg [N];
    logic signed [AW-1:0] z_reg [N-1];
    logic                 ng_reg [N];
    logic signed [AW-1:0] sn_reg, cs_reg;

    // wrap into [-pi, pi]
    always_comb begin
        if (a > PI_Q) begin
            a1_next = a - TWO_PI;
        end else if (a < -PI_Q) begin
            a1_next = a + TWO_PI;
        end else begin
            a1_next = a;
        end
    end

    // fold into [-pi/2, pi/2], negate both results later
    always_comb begin
        z0_next   = a1_reg;
        neg0_next = 1'b0;
        if (a1_reg > HALF) begin
            z0_next   = a1_reg - PI_Q;
            neg0_next = 1'b1;
        end else if (a1_reg < -HALF) begin
            z0_next   = a1_reg + PI_Q;
            neg0_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg   <= a1_next;
            z0_reg   <= z0_next;
            neg0_reg <= neg0_next;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_rot
        localparam logic signed [AW-1:0] ANG = AW'(stage_angle(F, i));
        logic signed [AW-1:0] xi, yi, zi, dx, dy;
        logic                 ni;
        if (i == 0) begin : g_first
            assign xi = X0;
            assign yi = '0;
            assign zi = z0_reg;
            assign ni = neg0_reg;
        end else begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign ni = ng_reg[i-1];
        end
        assign dx = yi >>> i;
        assign dy = xi >>> i;
        always_ff @(posedge aclk) begin
            if (en) begin
                ng_reg[i] <= ni;
                if (!zi[AW-1]) begin
                    x_reg[i] <= xi - dx;
                    y_reg[i] <= yi + dy;
                end else begin
                    x_reg[i] <= xi + dx;
                    y_reg[i] <= yi - dy;
                end
            end
        end
        if (i < N - 1) begin : g_z
            always_ff @(posedge aclk) begin
                if (en) begin
                    z_reg[i] <= zi[AW-1] ? zi + ANG : zi - ANG;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sn_reg <= ng_reg[N-1] ? -y_reg[N-1] : y_reg[N-1];
            cs_reg <= ng_reg[N-1] ? -x_reg[N-1] : x_reg[N-1];
        end
    end

    assign sn = sn_reg;
    assign cs = cs_reg;

endmodule

// File: rtl/core/great_circle_distance_unit.sv
// The pipe runs through the two CORDIC chains (sin/cos and atan2) and the
// one-bit-per-stage square roots.
// Throughput: one item per cycle; a held result stalls the pipe only when the last
// stage is also full.
// Reset (aresetn, synchronous, active low) clears the valid bits; data is not reset.
`include "great_circle_distance_unit_macros.svh"

module great_circle_distance_unit
    import gcd_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 30,
    parameter int CORDIC_STAGES   = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [30:0]       s_from_lat,
    input  logic signed [31:0]       s_from_lng,
    input  logic signed [30:0]       s_to_lat,
    input  logic signed [31:0]       s_to_lng,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [DIST_W-1:0]        m_distance_m
);

    localparam int F  = ANGLE_FRAC_BITS;
    localparam int N  = CORDIC_STAGES;
    localparam int AW = F + 5;         // angles and trig values, QF signed
    localparam int RW = 2 * F + 2;     // square root remainder
    localparam int DW = 32;            // distance before clamp
    // valid pipe: input reg 1, deg->rad 2, sincos N+3, products 4, h 1,
    // sqrt F+1, atan2 N, distance multiply 2
    localparam int L  = 2 * N + F + 14;

    localparam logic signed [63:0] UNIT_RAD = unit_rad_fix();
    localparam logic signed [63:0] TWO_R    = TWO_R_Q32;
    localparam logic [F:0]         ONE      = {1'b1, {F{1'b0}}};
    localparam logic signed [AW:0] ONE_W    = (AW + 1)'(1) << F;

    // ---------------------------------------------------------------
    // Flow control. All stages share one enable. The pipe moves when the
    // output register is free (or being taken) or when the last stage is
    // empty, so bubbles are squeezed out while a result waits.
    // ---------------------------------------------------------------
    logic [L-1:0]       vld_reg, vld_next;
    logic               out_free, en;
    logic               m_valid_reg, m_valid_next;
    logic [DIST_W-1:0]  m_dist_reg, m_dist_next;

    assign out_free = !m_valid_reg || m_ready;
    assign en       = out_free || !vld_reg[L-1];
    assign s_ready  = en;

    always_comb begin
        vld_next = en ? {vld_reg[L-2:0], s_valid} : vld_reg;
        if (vld_reg[L-1] && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            vld_reg     <= vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ---------------------------------------------------------------
    // Input register: latitudes and full-width coordinate differences.
    // ---------------------------------------------------------------
    logic signed [30:0] flat_reg, tlat_reg;
    logic signed [32:0] dlat_reg, dlng_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            flat_reg <= s_from_lat;
            tlat_reg <= s_to_lat;
            dlat_reg <= {{2{s_to_lat[30]}}, s_to_lat} - {{2{s_from_lat[30]}}, s_from_lat};
            dlng_reg <= {s_to_lng[31], s_to_lng} - {s_from_lng[31], s_from_lng};
        end
    end

    // ---------------------------------------------------------------
    // Degree units to radians. Half differences use one more shift.
    // ---------------------------------------------------------------
    logic signed [AW-1:0] lat1, lat2, hlat, hlng;

    gcd_mulrnd #(.AWD(31), .BWD(64), .SH(92 - F), .OW(AW)) u_lat1 (
        .aclk(aclk), .en(en), .a(flat_reg), .b(UNIT_RAD), .p(lat1));
    gcd_mulrnd #(.AWD(31), .BWD(64), .SH(92 - F), .OW(AW)) u_lat2 (
        .aclk(aclk), .en(en), .a(tlat_reg), .b(UNIT_RAD), .p(lat2));
    gcd_mulrnd #(.AWD(33), .BWD(64), .SH(93 - F), .OW(AW)) u_hlat (
        .aclk(aclk), .en(en), .a(dlat_reg), .b(UNIT_RAD), .p(hlat));
    gcd_mulrnd #(.AWD(33), .BWD(64), .SH(93 - F), .OW(AW)) u_hlng (
        .aclk(aclk), .en(en), .a(dlng_reg), .b(UNIT_RAD), .p(hlng));

    // ---------------------------------------------------------------
    // Four parallel sin/cos pipes. Only cos of the latitudes and sin of
    // the half differences feed the haversine term.
    // ---------------------------------------------------------------
    logic signed [AW-1:0] c1, c2, sl, sg;

    gcd_sincos #(.F(F), .N(N), .AW(AW)) u_sc_lat1 (
        .aclk(aclk), .en(en), .a(lat1), .sn(), .cs(c1));
    gcd_sincos #(.F(F), .N(N), .AW(AW)) u_sc_lat2 (
        .aclk(aclk), .en(en), .a(lat2), .sn(), .cs(c2));
    gcd_sincos #(.F(F), .N(N), .AW(AW)) u_sc_hlat (
        .aclk(aclk), .en(en), .a(hlat), .sn(sl), .cs());
    gcd_sincos #(.F(F), .N(N), .AW(AW)) u_sc_hlng (
        .aclk(aclk), .en(en), .a(hlng), .sn(sg), .cs());

    // ---------------------------------------------------------------
    // h = sl^2 + (c1*c2)*(sg^2), each product rounded to QF.
    // ---------------------------------------------------------------
    logic signed [AW-1:0] aterm, cc, gg, bterm;
    logic signed [AW-1:0] at_d1_reg, at_d2_reg;

    gcd_mulrnd #(.AWD(AW), .BWD(AW), .SH(F), .OW(AW)) u_ss (
        .aclk(aclk), .en(en), .a(sl), .b(sl), .p(aterm));
    gcd_mulrnd #(.AWD(AW), .BWD(AW), .SH(F), .OW(AW)) u_cc (
        .aclk(aclk), .en(en), .a(c1), .b(c2), .p(cc));
    gcd_mulrnd #(.AWD(AW), .BWD(AW), .SH(F), .OW(AW)) u_gg (
        .aclk(aclk), .en(en), .a(sg), .b(sg), .p(gg));
    gcd_mulrnd #(.AWD(AW), .BWD(AW), .SH(F), .OW(AW)) u_cg (
        .aclk(aclk), .en(en), .a(cc), .b(gg), .p(bterm));

    // match the second product's two stages
    always_ff @(posedge aclk) begin
        if (en) begin
            at_d1_reg <= aterm;
            at_d2_reg <= at_d1_reg;
        end
    end

    // sum and clamp to [0, 1]; 1-h formed alongside
    logic signed [AW:0] hs;
    logic [F:0]         h_next, h_reg, omh_reg;

    always_comb begin
        hs = {at_d2_reg[AW-1], at_d2_reg} + {bterm[AW-1], bterm};
        if (hs[AW]) begin
            h_next = '0;
        end else if (hs > ONE_W) begin
            h_next = ONE;
        end else begin
            h_next = hs[F:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_reg   <= h_next;
            omh_reg <= ONE - h_next;
        end
    end

    // ---------------------------------------------------------------
    // Floor square roots of h and 1-h (scaled by 2^F), one result bit
    // per stage, MSB first. Remainder tracks the radicand minus root^2.
    // ---------------------------------------------------------------
    logic [RW-1:0] sh_rem_reg  [F];
    logic [F:0]    sh_root_reg [F+1];
    logic [RW-1:0] sc_rem_reg  [F];
    logic [F:0]    sc_root_reg [F+1];

    for (genvar k = 0; k <= F; k++) begin : g_sqrt
        localparam int B = F - k;
        logic [RW-1:0] ha_rem, ca_rem, ha_trial, ca_trial;
        logic [F:0]    ha_root, ca_root;
        logic          ha_take, ca_take;
        if (k == 0) begin : g_first
            assign ha_rem  = RW'({h_reg, {F{1'b0}}});
            assign ca_rem  = RW'({omh_reg, {F{1'b0}}});
            assign ha_root = '0;
            assign ca_root = '0;
        end else begin : g_rest
            assign ha_rem  = sh_rem_reg[k-1];
            assign ca_rem  = sc_rem_reg[k-1];
            assign ha_root = sh_root_reg[k-1];
            assign ca_root = sc_root_reg[k-1];
        end
        assign ha_trial = (RW'(ha_root) << (B + 1)) + (RW'(1) << (2 * B));
        assign ca_trial = (RW'(ca_root) << (B + 1)) + (RW'(1) << (2 * B));
        assign ha_take  = ha_rem >= ha_trial;
        assign ca_take  = ca_rem >= ca_trial;
        always_ff @(posedge aclk) begin
            if (en) begin
                sh_root_reg[k] <= ha_take ? (ha_root | ((F + 1)'(1) << B)) : ha_root;
                sc_root_reg[k] <= ca_take ? (ca_root | ((F + 1)'(1) << B)) : ca_root;
            end
        end
        if (k < F) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    sh_rem_reg[k] <= ha_take ? ha_rem - ha_trial : ha_rem;
                    sc_rem_reg[k] <= ca_take ? ca_rem - ca_trial : ca_rem;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // atan2(sqrt(h), sqrt(1-h)) by vectoring: drive y to zero,
    // accumulate the angle in z.
    // ---------------------------------------------------------------
    logic signed [AW-1:0] vx_reg [N-1];
    logic signed [AW-1:0] vy_reg [N-1];
    logic signed [AW-1:0] vz_reg [N];

    for (genvar k = 0; k < N; k++) begin : g_vec
        localparam logic signed [AW-1:0] ANG = AW'(stage_angle(F, k));
        logic signed [AW-1:0] xi, yi, zi, dx, dy;
        logic                 ypos;
        if (k == 0) begin : g_first
            assign xi = AW'(sc_root_reg[F]);
            assign yi = AW'(sh_root_reg[F]);
            assign zi = '0;
        end else begin : g_rest
            assign xi = vx_reg[k-1];
            assign yi = vy_reg[k-1];
            assign zi = vz_reg[k-1];
        end
        assign dx   = yi >>> k;
        assign dy   = xi >>> k;
        assign ypos = !yi[AW-1] && (yi != '0);
        always_ff @(posedge aclk) begin
            if (en) begin
                vz_reg[k] <= ypos ? zi + ANG : zi - ANG;
            end
        end
        if (k < N - 1) begin : g_xy
            always_ff @(posedge aclk) begin
                if (en) begin
                    vx_reg[k] <= ypos ? xi + dx : xi - dx;
                    vy_reg[k] <= ypos ? yi - dy : yi + dy;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Distance = round(angle * 2R), clamped to the output range.
    // ---------------------------------------------------------------
    logic signed [DW-1:0] dist_p;

    gcd_mulrnd #(.AWD(AW), .BWD(64), .SH(F + 32), .OW(DW)) u_dist (
        .aclk(aclk), .en(en), .a(vz_reg[N-1]), .b(TWO_R), .p(dist_p));

    always_comb begin
        if (dist_p[DW-1]) begin
            m_dist_next = '0;
        end else if (dist_p[DW-2:0] > (DW - 1)'(DIST_MAX)) begin
            m_dist_next = DIST_MAX;
        end else begin
            m_dist_next = dist_p[DIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (vld_reg[L-1] && out_free) begin
            m_dist_reg <= m_dist_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_distance_m = m_dist_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `GCD_ASSERT_NXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, vld_reg[0], "accepted item missing from pipe")
    `GCD_ASSERT_IMP(a_full_stall, aclk, aresetn, m_valid && !m_ready && vld_reg[L-1], !s_ready, "input taken while pipe is blocked")
    `GCD_ASSERT_NXT(a_result_lands, aclk, aresetn, vld_reg[L-1] && out_free, m_valid, "finished item did not reach output")

endmodule

// File: test/tb_great_circle_distance_unit.sv
module tb_great_circle_distance_unit
    import gcd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // A directed table runs first: same-point rows have their zero distance typed in,
    // every other row goes through the bit-true fixed-point predictor below.
    // Random items follow in four phases of sender idling and receiver stalling.
    // Between phases the sender holds off until every expected distance has arrived.

    localparam int  FB         = 30;     // fractional bits of angles
    localparam int  NST        = 32;     // CORDIC stages
    localparam int  STALL_MAX  = 4000;   // cycles with no item moving on either side
    localparam int  TAIL_WAIT  = 250;    // cycles waited after the last phase
    localparam int  RAND_ITEMS = 325;    // per phase, four phases

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic signed [30:0]    s_from_lat;
    logic signed [31:0]    s_from_lng;
    logic signed [30:0]    s_to_lat;
    logic signed [31:0]    s_to_lng;
    logic                  m_valid;
    logic                  m_ready;
    logic [DIST_W-1:0]     m_distance_m;

    great_circle_distance_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_from_lat   (s_from_lat),
        .s_from_lng   (s_from_lng),
        .s_to_lat     (s_to_lat),
        .s_to_lng     (s_to_lng),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_distance_m (m_distance_m)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Fixed-point predictor: own tables, built once at time zero.
    // ------------------------------------------------------------------
    longint atan_tab [NST];   // atan(2^-i) in Q30
    longint x_start;          // 1/G in Q30
    longint rad_per_unit;     // pi / 1.8e9 in Q92
    longint pi_fix;           // pi in Q30

    // round(a*b / 2^s), ties away from zero, magnitude kept to 62 bits
    function automatic longint round_mul(input longint a, input longint b, input int s);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        logic [63:0]  r;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? 64'(-a) : 64'(a);
        ub  = (b < 0) ? 64'(-b) : 64'(b);
        p   = {64'd0, ua} * {64'd0, ub};
        p   = p + (128'd1 << (s - 1));
        r   = 64'(p >> s);
        r   = r & 64'h3FFF_FFFF_FFFF_FFFF;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [63:0] root_floor(input logic [127:0] n, input int top);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = top; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (({64'd0, c} * {64'd0, c}) <= n) begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic logic [127:0] div_nearest(input logic [127:0] n, input logic [127:0] d);
        logic [127:0] q;
        logic [127:0] r;
        q = n / d;
        r = n - q * d;
        if ((r << 1) >= d) begin
            q = q + 128'd1;
        end
        return q;
    endfunction

    task automatic build_trig_tables();
        logic [63:0] v;
        logic [63:0] p;
        logic [63:0] g;
        int          k;
        int          e;
        for (int i = 0; i < NST; i++) begin
            v = '0;
            if (i == 0) begin
                v = PI_Q60;
            end else begin
                k = 0;
                e = 62 - i;
                while (e >= 0) begin
                    if (k % 2 == 1) begin
                        v = v - (64'd1 << e) / 64'(2 * k + 1);
                    end else begin
                        v = v + (64'd1 << e) / 64'(2 * k + 1);
                    end
                    k++;
                    e = 62 - i * (2 * k + 1);
                end
            end
            atan_tab[i] = longint'((v + (64'd1 << (61 - FB))) >> (62 - FB));
        end
        p = 64'd1 << 62;
        for (int i = 0; i < NST; i++) begin
            if (2 * i < 64) begin
                p = p + (p >> (2 * i));
            end
        end
        g = root_floor({2'b00, p, 62'd0}, 62);
        x_start      = longint'(64'(div_nearest(128'd1 << (FB + 62), {64'd0, g})));
        rad_per_unit = longint'(64'(div_nearest({32'd0, PI_Q60, 32'd0}, 128'(UNITS_PER_PI))));
        pi_fix       = longint'((PI_Q60 + (64'd1 << (59 - FB))) >> (60 - FB));
    endtask

    task automatic sin_cos_fix(input longint a, output longint sn, output longint cs);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint half;
        bit     flip;
        x    = x_start;
        y    = 0;
        half = pi_fix >>> 1;
        flip = 1'b0;
        while (a > pi_fix) a -= 2 * pi_fix;
        while (a < -pi_fix) a += 2 * pi_fix;
        // fold the outer half-planes onto [-pi/2, pi/2], negate afterwards
        if (a > half) begin
            a -= pi_fix;
            flip = 1'b1;
        end else if (a < -half) begin
            a += pi_fix;
            flip = 1'b1;
        end
        z = a;
        for (int i = 0; i < NST; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= atan_tab[i];
            end else begin
                x += dx;
                y -= dy;
                z += atan_tab[i];
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endtask

    task automatic haversine_metres(input logic signed [30:0] fla, input logic signed [31:0] fln,
                                    input logic signed [30:0] tla, input logic signed [31:0] tln,
                                    output logic [DIST_W-1:0] metres);
        longint flat, flng, tlat, tlng;
        longint s1, c1, s2, c2, sl, cl, sg, cg;
        longint h, x, y, z, d, dx, dy;
        longint one;
        one  = longint'(1) << FB;
        flat = fla;
        flng = fln;
        tlat = tla;
        tlng = tln;
        sin_cos_fix(round_mul(flat, rad_per_unit, 92 - FB), s1, c1);
        sin_cos_fix(round_mul(tlat, rad_per_unit, 92 - FB), s2, c2);
        sin_cos_fix(round_mul(tlat - flat, rad_per_unit, 93 - FB), sl, cl);
        sin_cos_fix(round_mul(tlng - flng, rad_per_unit, 93 - FB), sg, cg);
        h = round_mul(sl, sl, FB)
          + round_mul(round_mul(c1, c2, FB), round_mul(sg, sg, FB), FB);
        if (h < 0) h = 0;
        if (h > one) h = one;
        y = longint'(root_floor(128'(h) << FB, FB));
        x = longint'(root_floor(128'(one - h) << FB, FB));
        z = 0;
        // vectoring: drive y to zero, z collects the half central angle
        for (int i = 0; i < NST; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx;
                y -= dy;
                z += atan_tab[i];
            end else begin
                x -= dx;
                y += dy;
                z -= atan_tab[i];
            end
        end
        d = round_mul(z, longint'(TWO_R_Q32), FB + 32);
        if (d < 0) d = 0;
        if (d > longint'(DIST_MAX)) d = longint'(DIST_MAX);
        metres = DIST_W'(d);
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct packed {
        logic signed [30:0] fla;
        logic signed [31:0] fln;
        logic signed [30:0] tla;
        logic signed [31:0] tln;
        bit                 typed;   // distance below is known by inspection
        logic [DIST_W-1:0]  exp_m;
    } trip_row_t;

    localparam int N_DIR = 17;
    trip_row_t trip_table [N_DIR] = '{
        // identical points give zero
        '{31'sd0, 32'sd0, 31'sd0, 32'sd0, 1'b1, 25'd0},
        '{31'sd900000000, 32'sd1800000000, 31'sd900000000, 32'sd1800000000, 1'b1, 25'd0},
        '{-31'sd900000000, -32'sd1800000000, -31'sd900000000, -32'sd1800000000, 1'b1, 25'd0},
        // pole to pole, equatorial antipodes, dateline wrap
        '{31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0, 1'b0, 25'd0},
        '{31'sd0, 32'sd0, 31'sd0, 32'sd1800000000, 1'b0, 25'd0},
        '{31'sd0, -32'sd1800000000, 31'sd0, 32'sd1800000000, 1'b0, 25'd0},
        '{31'sd0, 32'sd1800000000, 31'sd0, -32'sd1800000000, 1'b0, 25'd0},
        // one-unit steps
        '{31'sd0, 32'sd1, 31'sd0, 32'sd0, 1'b0, 25'd0},
        '{31'sd1, 32'sd0, 31'sd0, 32'sd0, 1'b0, 25'd0},
        // raw field extremes, far out of range
        '{-31'sd1073741824, -32'sd2147483648, 31'sd1073741823, 32'sd2147483647, 1'b0, 25'd0},
        '{31'sd1073741823, 32'sd2147483647, -31'sd1073741824, -32'sd2147483648, 1'b0, 25'd0},
        // antipodal and near antipodal
        '{31'sd450000000, 32'sd900000000, -31'sd450000000, -32'sd900000000, 1'b0, 25'd0},
        '{31'sd123456789, -32'sd987654321, -31'sd123456789, 32'sd812345679, 1'b0, 25'd0},
        '{-31'sd900000000, 32'sd0, 31'sd900000000, 32'sd1800000000, 1'b0, 25'd0},
        // ordinary city pairs
        '{31'sd515074000, -32'sd1278000, 31'sd407128000, -32'sd740060000, 1'b0, 25'd0},
        '{-31'sd338688000, 32'sd1512093000, 31'sd515074000, -32'sd1278000, 1'b0, 25'd0},
        // same pole reached from two longitudes
        '{31'sd900000000, 32'sd123, 31'sd900000000, -32'sd1800000000, 1'b0, 25'd0}
    };

    // ------------------------------------------------------------------
    // Scoreboard state
    // ------------------------------------------------------------------
    logic [DIST_W-1:0] pending_dist [$];
    int  idle_pct;
    int  stall_pct;
    int  n_sent;
    int  n_checked;
    int  n_bad;
    int  stall_run;

    // Receiver backpressure, re-rolled each cycle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each delivered distance against the oldest pending one.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_dist.size() == 0) begin
                $display("%0t: unexpected item, distance_m=%0d", $time, m_distance_m);
                n_bad++;
            end else begin
                if (m_distance_m !== pending_dist[0]) begin
                    $display("%0t: distance_m mismatch, expected %0d, actual %0d",
                             $time, pending_dist[0], m_distance_m);
                    n_bad++;
                end
                void'(pending_dist.pop_front());
                n_checked++;
            end
        end
    end

    // Watchdog: count cycles in which no item moves on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_run <= 0;
        end else begin
            stall_run <= stall_run + 1;
            if (stall_run >= STALL_MAX) begin
                $display("%0t: timeout, %0d items still pending", $time, pending_dist.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Present one trip, wait for acceptance, then maybe idle.
    task automatic send_trip(input trip_row_t t);
        logic [DIST_W-1:0] d;
        s_valid    <= 1'b1;
        s_from_lat <= t.fla;
        s_from_lng <= t.fln;
        s_to_lat   <= t.tla;
        s_to_lng   <= t.tln;
        do @(posedge aclk); while (!s_ready);
        if (t.typed) begin
            d = t.exp_m;
        end else begin
            haversine_metres(t.fla, t.fln, t.tla, t.tln, d);
        end
        pending_dist.insert(pending_dist.size(), d);
        n_sent++;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_dist.size() != 0) @(posedge aclk);
    endtask

    function automatic trip_row_t random_trip();
        trip_row_t t;
        int        mode;
        longint    flat, flng, tlat, tlng;
        mode = $urandom_range(99);
        flat = longint'($urandom_range(1800000000)) - 900000000;
        flng = longint'($urandom_range(32'd3600000000)) - 1800000000;
        tlat = longint'($urandom_range(1800000000)) - 900000000;
        tlng = longint'($urandom_range(32'd3600000000)) - 1800000000;
        if (mode < 60) begin
            // independent points in range
        end else if (mode < 80) begin
            // short hops
            tlat = flat + longint'($urandom_range(10000000)) - 5000000;
            tlng = flng + longint'($urandom_range(10000000)) - 5000000;
        end else if (mode < 90) begin
            // close to antipodal
            tlat = -flat + longint'($urandom_range(2000000)) - 1000000;
            tlng = (flng >= 0 ? flng - 1800000000 : flng + 1800000000)
                 + longint'($urandom_range(2000000)) - 1000000;
        end else begin
            // any bit pattern the fields allow
            flat = longint'($signed(31'($urandom())));
            flng = longint'($signed(32'($urandom())));
            tlat = longint'($signed(31'($urandom())));
            tlng = longint'($signed(32'($urandom())));
        end
        t.fla   = 31'(flat);
        t.fln   = 32'(flng);
        t.tla   = 31'(tlat);
        t.tln   = 32'(tlng);
        t.typed = 1'b0;
        t.exp_m = '0;
        return t;
    endfunction

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_from_lat = '0;
        s_from_lng = '0;
        s_to_lat   = '0;
        s_to_lng   = '0;
        idle_pct   = 0;
        stall_pct  = 0;
        n_sent     = 0;
        build_trig_tables();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows, back to back
        foreach (trip_table[i]) send_trip(trip_table[i]);
        drain();

        // random phases: (sender idle %, receiver stall %)
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 75; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            for (int n = 0; n < RAND_ITEMS; n++) send_trip(random_trip());
            // hold off until everything sent so far has come back
            drain();
        end

        stall_pct = 0;
        repeat (TAIL_WAIT) @(posedge aclk);

        $display("Covered %0d trips (%0d table rows, rest random over four idle/stall mixes).",
                 n_sent, N_DIR);
        $display("Distances compared: %0d, mismatches: %0d, left pending: %0d.",
                 n_checked, n_bad, pending_dist.size());
        if (n_bad == 0 && pending_dist.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
